// ----- src/vca_pkg.sv -----
// Package for the velocity command arbiter: item structs, op, mode, source and
// register index codes. No dependencies.
package vca_pkg;

   localparam int TIME_BITS     = 32;
   localparam int VEL_BITS      = 32;
   localparam int TMO_BITS      = 31;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_MANUAL  = 3'd1,
      OP_AUTO    = 3'd2,
      OP_MODE    = 3'd3,
      OP_AUTO_EN = 3'd4,
      OP_DEADMAN = 3'd5,
      OP_ESTOP   = 3'd6,
      OP_UNUSED  = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      MODE_STOP   = 2'd0,
      MODE_MANUAL = 2'd1,
      MODE_AUTO   = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      SRC_ESTOP          = 3'd0,
      SRC_TRANSITION     = 3'd1,
      SRC_STOP           = 3'd2,
      SRC_MANUAL         = 3'd3,
      SRC_MANUAL_TIMEOUT = 3'd4,
      SRC_MANUAL_IDLE    = 3'd5,
      SRC_AUTO           = 3'd6,
      SRC_AUTO_WAIT      = 3'd7
   } source_type;

   // previous-source register holds one extra code for "nothing emitted yet"
   localparam logic [3:0] PREV_SRC_NONE = 4'd8;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MANUAL_TIMEOUT = 3'd0,
      CSR_AUTO_TIMEOUT   = 3'd1,
      CSR_MODE_HOLD      = 3'd2,
      CSR_NEEDS_DEADMAN  = 3'd3
   } csr_index_type;

   localparam logic [TMO_BITS-1:0] MANUAL_TIMEOUT_RST = 31'd500000;
   localparam logic [TMO_BITS-1:0] AUTO_TIMEOUT_RST   = 31'd500000;
   localparam logic [TMO_BITS-1:0] MODE_HOLD_RST      = 31'd150000;

   typedef struct packed {
      logic signed [VEL_BITS-1:0] lin_x;
      logic signed [VEL_BITS-1:0] lin_y;
      logic signed [VEL_BITS-1:0] lin_z;
      logic signed [VEL_BITS-1:0] ang_x;
      logic signed [VEL_BITS-1:0] ang_y;
      logic signed [VEL_BITS-1:0] ang_z;
   } vel_type;

   typedef struct packed {
      logic [2:0]                 op;
      logic [TIME_BITS-1:0]       now_time;
      logic [TIME_BITS-1:0]       cmd_stamp;
      logic signed [VEL_BITS-1:0] lin_x;
      logic signed [VEL_BITS-1:0] lin_y;
      logic signed [VEL_BITS-1:0] lin_z;
      logic signed [VEL_BITS-1:0] ang_x;
      logic signed [VEL_BITS-1:0] ang_y;
      logic signed [VEL_BITS-1:0] ang_z;
      logic [1:0]                 setting;
   } req_item_type;

   typedef struct packed {
      logic [2:0]                 source;
      logic                       source_changed;
      logic [TIME_BITS-1:0]       out_stamp;
      logic signed [VEL_BITS-1:0] out_lin_x;
      logic signed [VEL_BITS-1:0] out_lin_y;
      logic signed [VEL_BITS-1:0] out_lin_z;
      logic signed [VEL_BITS-1:0] out_ang_x;
      logic signed [VEL_BITS-1:0] out_ang_y;
      logic signed [VEL_BITS-1:0] out_ang_z;
   } rsp_item_type;

endpackage

// ----- src/velocity_command_arbiter.sv -----
// Velocity command arbiter top level: event state, tick selection, result register.
// Depends on vca_pkg.

// One item is accepted per clock while req_stall is low. Event items (manual or auto
// command, mode, auto enable, deadman, estop) update stored state at the edge that
// accepts them and give no result; a tick item is arbitrated against the state left
// by all earlier items and its result appears in the output register in the
// following cycle. The only stall source is that single result register: req_stall
// is high while a result waits and rsp_stall holds it, so a stalled consumer costs
// one result of backlog and no more. Configuration writes are always ready.
module velocity_command_arbiter
   import vca_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_item_type             req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_item_type             rsp_item,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   logic [TMO_BITS-1:0]  manual_tmo_ff, auto_tmo_ff, mode_hold_ff;
   logic                 needs_deadman_ff;

   mode_type             mode_ff;
   logic [TIME_BITS-1:0] mode_time_ff;
   logic                 manual_valid_ff, auto_valid_ff;
   logic [TIME_BITS-1:0] manual_time_ff, auto_time_ff;
   vel_type              manual_vel_ff, auto_vel_ff;
   logic                 auto_allowed_ff, deadman_ff, estop_ff;
   logic [3:0]           prev_src_ff;

   logic                 rsp_valid_ff;
   rsp_item_type         rsp_item_ff, rsp_item_in;

   logic                 req_accept, tick_accept, flag;
   mode_type             req_mode;
   vel_type              req_vel, sel_vel;
   source_type           src;
   logic [TIME_BITS-1:0] mode_elapsed, manual_age, auto_age;
   logic                 in_transition, manual_fresh, auto_fresh;

   assign req_stall   = rsp_valid_ff & rsp_stall;
   assign req_accept  = req_valid & ~req_stall;
   assign tick_accept = req_accept & (req_item.op == OP_TICK);
   assign flag        = (req_item.setting != 2'd0);
   assign csr_ready   = 1'b1;

   assign req_vel = '{lin_x: req_item.lin_x, lin_y: req_item.lin_y, lin_z: req_item.lin_z,
                      ang_x: req_item.ang_x, ang_y: req_item.ang_y, ang_z: req_item.ang_z};

   always_comb begin
      case (req_item.setting)
         2'd1:    req_mode = MODE_MANUAL;
         2'd2:    req_mode = MODE_AUTO;
         default: req_mode = MODE_STOP;
      endcase
   end

   // wrapping ages: a stamp ahead of now reads as very old
   assign mode_elapsed  = req_item.now_time - mode_time_ff;
   assign manual_age    = req_item.now_time - manual_time_ff;
   assign auto_age      = req_item.now_time - auto_time_ff;
   assign in_transition = mode_elapsed < {1'b0, mode_hold_ff};
   assign manual_fresh  = manual_valid_ff && (manual_time_ff != '0)
                          && (manual_age <= {1'b0, manual_tmo_ff});
   assign auto_fresh    = auto_valid_ff && (auto_time_ff != '0)
                          && (auto_age <= {1'b0, auto_tmo_ff});

   always_comb begin
      sel_vel = '0;
      if (estop_ff) begin
         src = SRC_ESTOP;
      end else if (in_transition) begin
         src = SRC_TRANSITION;
      end else begin
         case (mode_ff)
            MODE_MANUAL: begin
               if ((!needs_deadman_ff || deadman_ff) && manual_fresh) begin
                  src     = SRC_MANUAL;
                  sel_vel = manual_vel_ff;
               end else begin
                  src = deadman_ff ? SRC_MANUAL_TIMEOUT : SRC_MANUAL_IDLE;
               end
            end
            MODE_AUTO: begin
               if (auto_allowed_ff && auto_fresh) begin
                  src     = SRC_AUTO;
                  sel_vel = auto_vel_ff;
               end else begin
                  src = SRC_AUTO_WAIT;
               end
            end
            default: src = SRC_STOP;
         endcase
      end
   end

   always_comb begin
      rsp_item_in.source         = src;
      rsp_item_in.source_changed = ({1'b0, src} != prev_src_ff);
      rsp_item_in.out_stamp      = req_item.now_time;
      rsp_item_in.out_lin_x      = sel_vel.lin_x;
      rsp_item_in.out_lin_y      = sel_vel.lin_y;
      rsp_item_in.out_lin_z      = sel_vel.lin_z;
      rsp_item_in.out_ang_x      = sel_vel.ang_x;
      rsp_item_in.out_ang_y      = sel_vel.ang_y;
      rsp_item_in.out_ang_z      = sel_vel.ang_z;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         manual_tmo_ff    <= MANUAL_TIMEOUT_RST;
         auto_tmo_ff      <= AUTO_TIMEOUT_RST;
         mode_hold_ff     <= MODE_HOLD_RST;
         needs_deadman_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MANUAL_TIMEOUT: manual_tmo_ff    <= csr_data[TMO_BITS-1:0];
            CSR_AUTO_TIMEOUT:   auto_tmo_ff      <= csr_data[TMO_BITS-1:0];
            CSR_MODE_HOLD:      mode_hold_ff     <= csr_data[TMO_BITS-1:0];
            CSR_NEEDS_DEADMAN:  needs_deadman_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // event state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_STOP;
         mode_time_ff    <= '0;
         manual_valid_ff <= 1'b0;
         manual_time_ff  <= '0;
         manual_vel_ff   <= '0;
         auto_valid_ff   <= 1'b0;
         auto_time_ff    <= '0;
         auto_vel_ff     <= '0;
         auto_allowed_ff <= 1'b0;
         deadman_ff      <= 1'b0;
         estop_ff        <= 1'b0;
      end else if (req_accept) begin
         case (req_item.op)
            OP_MANUAL: begin
               manual_valid_ff <= 1'b1;
               manual_time_ff  <= req_item.cmd_stamp;
               manual_vel_ff   <= req_vel;
            end
            OP_AUTO: begin
               auto_valid_ff <= 1'b1;
               auto_time_ff  <= req_item.cmd_stamp;
               auto_vel_ff   <= req_vel;
            end
            OP_MODE: begin
               // same mode again keeps the change time
               if (req_mode != mode_ff) begin
                  mode_ff      <= req_mode;
                  mode_time_ff <= req_item.now_time;
               end
            end
            OP_AUTO_EN: auto_allowed_ff <= flag;
            OP_DEADMAN: deadman_ff      <= flag;
            OP_ESTOP:   estop_ff        <= flag;
            default: ;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_src_ff  <= PREV_SRC_NONE;
      end else if (tick_accept) begin
         rsp_valid_ff <= 1'b1;
         prev_src_ff  <= {1'b0, src};
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- src/vca_checker.sv -----
// Port-level checks for the velocity command arbiter, bound to the top level.
// Depends on vca_pkg.
module vca_checker
   import vca_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input req_item_type             req_item,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input rsp_item_type             rsp_item
);

   logic zero_vel;
   assign zero_vel = (rsp_item.out_lin_x == '0) && (rsp_item.out_lin_y == '0)
                     && (rsp_item.out_lin_z == '0) && (rsp_item.out_ang_x == '0)
                     && (rsp_item.out_ang_y == '0) && (rsp_item.out_ang_z == '0);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_item.op == OP_TICK)
      |=> rsp_valid && (rsp_item.out_stamp == $past(req_item.now_time)))
      else $error("accepted tick gave no matching result");

   a_zero_unless_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !(rsp_item.source == SRC_MANUAL || rsp_item.source == SRC_AUTO)
      |-> zero_vel)
      else $error("nonzero velocity for a forced-stop source");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

endmodule

bind velocity_command_arbiter vca_checker u_vca_checker (.*);

// ----- bench/velocity_command_arbiter_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for velocity_command_arbiter: a directed event table, then random
// event streams under several register settings. Depends on vca_pkg and the RTL top.
module velocity_command_arbiter_tb;
   import vca_pkg::*;

   localparam int CYCLE_LIMIT     = 600000;
   localparam int ITEMS_PER_PHASE = 255;
   localparam int NUM_PHASES      = 6;
   localparam int SETTLE_CYCLES   = 4;
   localparam int MAX_PRINTS      = 100;

   typedef struct {
      req_item_type item;
      bit           typed;
      source_type   want_src;
      bit           want_chg;
   } dir_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_item_type             req_item;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_item_type             rsp_item;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   // arbitration state as the bench sees it
   logic [TMO_BITS-1:0]  cfg_manual_tmo, cfg_auto_tmo, cfg_hold;
   logic                 cfg_need_deadman;
   mode_type             sel_mode;
   logic [TIME_BITS-1:0] mode_since, man_stamp, auto_stamp;
   logic                 man_have, auto_have, auto_on, deadman_on, estop_on;
   vel_type              man_vel, auto_vel;
   logic [3:0]           last_source;

   rsp_item_type due_outputs[$];
   rsp_item_type oldest;
   int           mismatches;
   int           cycles;
   int           stall_run;
   bit           stall_now;
   bit           calm;

   velocity_command_arbiter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic req_item_type item_of(op_type op, logic [TIME_BITS-1:0] now,
                                            logic [TIME_BITS-1:0] stamp,
                                            logic [1:0] setting, vel_type v);
      req_item_type it;
      it = '0;
      it.op = op;
      it.now_time = now;
      it.cmd_stamp = stamp;
      it.setting = setting;
      {it.lin_x, it.lin_y, it.lin_z, it.ang_x, it.ang_y, it.ang_z} = v;
      return it;
   endfunction

   function automatic bit is_fresh(logic have, logic [TIME_BITS-1:0] stamp,
                                   logic [TIME_BITS-1:0] now, logic [TMO_BITS-1:0] limit);
      logic [TIME_BITS-1:0] age;
      age = now - stamp;
      return have && (stamp != '0) && (age <= TIME_BITS'(limit));
   endfunction

   task automatic arbitrate(input req_item_type it, output bit emits, output rsp_item_type res);
      logic [TIME_BITS-1:0] since;
      source_type           src;
      vel_type              v;
      mode_type             next_mode;
      emits = 1'b0;
      res = '0;
      v = '0;
      case (op_type'(it.op))
         OP_MANUAL: begin
            man_have = 1'b1;
            man_stamp = it.cmd_stamp;
            man_vel = {it.lin_x, it.lin_y, it.lin_z, it.ang_x, it.ang_y, it.ang_z};
         end
         OP_AUTO: begin
            auto_have = 1'b1;
            auto_stamp = it.cmd_stamp;
            auto_vel = {it.lin_x, it.lin_y, it.lin_z, it.ang_x, it.ang_y, it.ang_z};
         end
         OP_MODE: begin
            // setting three falls back to stop; same mode keeps the change time
            next_mode = (it.setting == 2'd3) ? MODE_STOP : mode_type'(it.setting);
            if (next_mode != sel_mode) begin
               sel_mode = next_mode;
               mode_since = it.now_time;
            end
         end
         OP_AUTO_EN: auto_on = (it.setting != '0);
         OP_DEADMAN: deadman_on = (it.setting != '0);
         OP_ESTOP:   estop_on = (it.setting != '0);
         OP_TICK: begin
            since = it.now_time - mode_since;
            if (estop_on) begin
               src = SRC_ESTOP;
            end else if (since < TIME_BITS'(cfg_hold)) begin
               src = SRC_TRANSITION;
            end else if (sel_mode == MODE_MANUAL) begin
               if ((!cfg_need_deadman || deadman_on) &&
                   is_fresh(man_have, man_stamp, it.now_time, cfg_manual_tmo)) begin
                  src = SRC_MANUAL;
                  v = man_vel;
               end else begin
                  src = deadman_on ? SRC_MANUAL_TIMEOUT : SRC_MANUAL_IDLE;
               end
            end else if (sel_mode == MODE_AUTO) begin
               if (auto_on && is_fresh(auto_have, auto_stamp, it.now_time, cfg_auto_tmo)) begin
                  src = SRC_AUTO;
                  v = auto_vel;
               end else begin
                  src = SRC_AUTO_WAIT;
               end
            end else begin
               src = SRC_STOP;
            end
            res.source = src;
            res.source_changed = ({1'b0, src} != last_source);
            res.out_stamp = it.now_time;
            {res.out_lin_x, res.out_lin_y, res.out_lin_z,
             res.out_ang_x, res.out_ang_y, res.out_ang_z} = v;
            last_source = {1'b0, src};
            emits = 1'b1;
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input req_item_type it, input bit typed, input rsp_item_type want);
      bit           emits;
      rsp_item_type res;
      int           gap;
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      arbitrate(it, emits, res);
      if (emits)
         due_outputs.push_back(typed ? want : res);
      gap = 0;
      if (!calm && ($urandom_range(0, 99) < 40))
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (csr_index_type'(idx))
         CSR_MANUAL_TIMEOUT: cfg_manual_tmo = data[TMO_BITS-1:0];
         CSR_AUTO_TIMEOUT:   cfg_auto_tmo = data[TMO_BITS-1:0];
         CSR_MODE_HOLD:      cfg_hold = data[TMO_BITS-1:0];
         CSR_NEEDS_DEADMAN:  cfg_need_deadman = data[0];
         default: ;
      endcase
   endtask

   // hold the sender until every due result is out, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (due_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("%0t: %s got %h, want %h", $time, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_outputs.size() == 0) begin
            report_mismatch("result with nothing due, stamp", rsp_item.out_stamp, '0);
         end else begin
            oldest = due_outputs.pop_front();
            check_field("source", 32'(rsp_item.source), 32'(oldest.source));
            check_field("source_changed", 32'(rsp_item.source_changed),
                        32'(oldest.source_changed));
            check_field("out_stamp", rsp_item.out_stamp, oldest.out_stamp);
            check_field("out_lin_x", rsp_item.out_lin_x, oldest.out_lin_x);
            check_field("out_lin_y", rsp_item.out_lin_y, oldest.out_lin_y);
            check_field("out_lin_z", rsp_item.out_lin_z, oldest.out_lin_z);
            check_field("out_ang_x", rsp_item.out_ang_x, oldest.out_ang_x);
            check_field("out_ang_y", rsp_item.out_ang_y, oldest.out_ang_y);
            check_field("out_ang_z", rsp_item.out_ang_z, oldest.out_ang_z);
         end
      end
   end

   // consumer stall: mostly short runs, now and then a long one, none while calm
   always @(posedge clock) begin
      if (stall_run <= 0) begin
         stall_now = !calm && ($urandom_range(0, 99) < 35);
         if (stall_now)
            stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                     : $urandom_range(1, 3);
         else
            stall_run = $urandom_range(1, 8);
      end
      stall_run--;
      rsp_stall <= stall_now;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[velocity_command_arbiter] ERROR");
         $finish;
      end
   end

   initial begin
      dir_row_type              rows[$];
      req_item_type             it;
      rsp_item_type             want;
      logic [6*VEL_BITS-1:0]    vbits;
      logic [TIME_BITS-1:0]     now_us;
      logic [TIME_BITS-1:0]     stamp;
      int                       pick;
      int                       counted;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_item  <= '0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;

      cfg_manual_tmo   = MANUAL_TIMEOUT_RST;
      cfg_auto_tmo     = AUTO_TIMEOUT_RST;
      cfg_hold         = MODE_HOLD_RST;
      cfg_need_deadman = 1'b1;
      sel_mode   = MODE_STOP;
      mode_since = '0;
      man_have   = 1'b0;
      man_stamp  = '0;
      man_vel    = '0;
      auto_have  = 1'b0;
      auto_stamp = '0;
      auto_vel   = '0;
      auto_on    = 1'b0;
      deadman_on = 1'b0;
      estop_on   = 1'b0;
      last_source = PREV_SRC_NONE;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed events under reset register values
      rows.push_back('{item_of(OP_TICK, 32'd0, '0, '0, '0), 1'b1, SRC_TRANSITION, 1'b1});
      rows.push_back('{item_of(OP_TICK, 32'd150000, '0, '0, '0), 1'b1, SRC_STOP, 1'b1});
      rows.push_back('{item_of(OP_ESTOP, 32'd160000, '0, 2'd1, '0), 1'b0, SRC_ESTOP, 1'b0});
      rows.push_back('{item_of(OP_TICK, 32'd200000, '0, '0, '0), 1'b1, SRC_ESTOP, 1'b1});
      rows.push_back('{item_of(OP_ESTOP, 32'd210000, '0, 2'd0, '0), 1'b0, SRC_ESTOP, 1'b0});
      rows.push_back('{item_of(OP_MODE, 32'd1000000, '0, MODE_MANUAL, '0),
                       1'b0, SRC_ESTOP, 1'b0});
      rows.push_back('{item_of(OP_TICK, 32'd1100000, '0, '0, '0), 1'b1, SRC_TRANSITION, 1'b1});
      rows.push_back('{item_of(OP_MANUAL, 32'd1150000, 32'd1150000, '0,
                               vel_type'({32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                          32'h0000_0000, 32'h0000_0001, 32'h1234_5678})),
                       1'b0, SRC_ESTOP, 1'b0});
      rows.push_back('{item_of(OP_TICK, 32'd1200000, '0, '0, '0), 1'b1, SRC_MANUAL_IDLE, 1'b1});
      rows.push_back('{item_of(OP_DEADMAN, 32'd1250000, '0, 2'd3, '0), 1'b0, SRC_ESTOP, 1'b0});
      rows.push_back('{item_of(OP_TICK, 32'd1300000, '0, '0, '0), 1'b0, SRC_ESTOP, 1'b0});
      // age exactly at the timeout is still fresh, one past it is not
      rows.push_back('{item_of(OP_TICK, 32'd1650000, '0, '0, '0), 1'b0, SRC_ESTOP, 1'b0});
      rows.push_back('{item_of(OP_TICK, 32'd1650001, '0, '0, '0),
                       1'b1, SRC_MANUAL_TIMEOUT, 1'b1});
      rows.push_back('{item_of(OP_MANUAL, 32'd1690000, '0, '0,
                               vel_type'({6{32'h5A5A_A5A5}})), 1'b0, SRC_ESTOP, 1'b0});
      rows.push_back('{item_of(OP_TICK, 32'd1700000, '0, '0, '0),
                       1'b1, SRC_MANUAL_TIMEOUT, 1'b0});
      // stamp ahead of now counts as very old
      rows.push_back('{item_of(OP_MANUAL, 32'd1700000, 32'hFFFF_FFFF, '0,
                               vel_type'({6{32'h0F0F_F0F0}})), 1'b0, SRC_ESTOP, 1'b0});
      rows.push_back('{item_of(OP_TICK, 32'd1700000, '0, '0, '0),
                       1'b1, SRC_MANUAL_TIMEOUT, 1'b0});
      rows.push_back('{item_of(OP_MODE, 32'd1790000, '0, MODE_MANUAL, '0),
                       1'b0, SRC_ESTOP, 1'b0});
      rows.push_back('{item_of(OP_TICK, 32'd1800000, '0, '0, '0),
                       1'b1, SRC_MANUAL_TIMEOUT, 1'b0});
      rows.push_back('{item_of(OP_MODE, 32'd2000000, '0, MODE_AUTO, '0), 1'b0, SRC_ESTOP, 1'b0});
      rows.push_back('{item_of(OP_AUTO, 32'd2100000, 32'd2100000, '0,
                               vel_type'({32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
                                          32'hFFFF_0000, 32'h0000_8000, 32'hDEAD_BEEF})),
                       1'b0, SRC_ESTOP, 1'b0});
      rows.push_back('{item_of(OP_AUTO_EN, 32'd2150000, '0, 2'd2, '0), 1'b0, SRC_ESTOP, 1'b0});
      rows.push_back('{item_of(OP_TICK, 32'd2200000, '0, '0, '0), 1'b0, SRC_ESTOP, 1'b0});
      rows.push_back('{item_of(OP_AUTO_EN, 32'd2200000, '0, 2'd0, '0), 1'b0, SRC_ESTOP, 1'b0});
      rows.push_back('{item_of(OP_TICK, 32'd2200001, '0, '0, '0), 1'b1, SRC_AUTO_WAIT, 1'b1});
      // setting three selects stop
      rows.push_back('{item_of(OP_MODE, 32'd3000000, '0, 2'd3, '0), 1'b0, SRC_ESTOP, 1'b0});
      rows.push_back('{item_of(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3,
                               vel_type'({6{32'hFFFF_FFFF}})), 1'b0, SRC_ESTOP, 1'b0});
      rows.push_back('{item_of(OP_TICK, 32'hFFFF_FFFF, '0, '0, '0), 1'b1, SRC_STOP, 1'b1});

      foreach (rows[i]) begin
         want = '0;
         want.source = rows[i].want_src;
         want.source_changed = rows[i].want_chg;
         want.out_stamp = rows[i].item.now_time;
         send_item(rows[i].item, rows[i].typed, want);
      end

      now_us = 32'd5000000;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            1: begin
               write_reg(CSR_MANUAL_TIMEOUT, '0);
               write_reg(CSR_AUTO_TIMEOUT, '0);
               write_reg(CSR_MODE_HOLD, '0);
               write_reg(CSR_NEEDS_DEADMAN, '0);
            end
            2: begin
               write_reg(CSR_MANUAL_TIMEOUT, 32'h7FFF_FFFF);
               write_reg(CSR_AUTO_TIMEOUT, 32'h7FFF_FFFF);
               write_reg(CSR_MODE_HOLD, 32'h7FFF_FFFF);
               write_reg(CSR_NEEDS_DEADMAN, 32'd1);
            end
            3: begin
               write_reg(CSR_MANUAL_TIMEOUT, 32'd200000);
               write_reg(CSR_AUTO_TIMEOUT, 32'd300000);
               write_reg(CSR_MODE_HOLD, 32'd50000);
               write_reg(CSR_NEEDS_DEADMAN, 32'd0);
            end
            4: begin
               write_reg(CSR_MANUAL_TIMEOUT, $urandom_range(0, 800000));
               write_reg(CSR_AUTO_TIMEOUT, $urandom_range(0, 800000));
               write_reg(CSR_MODE_HOLD, $urandom_range(0, 300000));
               write_reg(CSR_NEEDS_DEADMAN, $urandom_range(0, 1));
            end
            5: begin
               // drop data bits above the register width, ignore unknown indexes
               write_reg(CSR_MANUAL_TIMEOUT, 32'hFFFF_FFFF);
               write_reg(CSR_AUTO_TIMEOUT, 32'h8000_0000 | 32'd400000);
               write_reg(CSR_MODE_HOLD, 32'h8000_0000 | 32'd100000);
               write_reg(CSR_NEEDS_DEADMAN, 32'hFFFF_FFFE);
               for (int k = int'(CSR_NEEDS_DEADMAN) + 1; k < (1 << CSR_IDX_BITS); k++)
                  write_reg(k[CSR_IDX_BITS-1:0], $urandom);
            end
            default: ;
         endcase
         csr_valid <= 1'b0;

         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            if (counted % 64 == 0)
               calm = ($urandom_range(0, 3) == 0);
            if (counted == ITEMS_PER_PHASE / 2)
               wait_idle();

            pick = $urandom_range(0, 99);
            if (pick < 80)
               now_us += $urandom_range(0, 120000);
            else if (pick < 95)
               now_us += $urandom_range(120000, 700000);
            else if (pick < 98)
               now_us = $urandom;

            pick = $urandom_range(0, 99);
            if (pick < 30)
               stamp = now_us;
            else if (pick < 70)
               stamp = now_us - $urandom_range(0, 700000);
            else if (pick < 80)
               stamp = '0;
            else if (pick < 90)
               stamp = $urandom;
            else
               stamp = now_us + $urandom_range(1, 1000);

            for (int k = 0; k < 6; k++) begin
               pick = $urandom_range(0, 19);
               if (pick == 0)
                  vbits[k*VEL_BITS +: VEL_BITS] = 32'h7FFF_FFFF;
               else if (pick == 1)
                  vbits[k*VEL_BITS +: VEL_BITS] = 32'h8000_0000;
               else if (pick == 2)
                  vbits[k*VEL_BITS +: VEL_BITS] = {VEL_BITS{1'b1}};
               else
                  vbits[k*VEL_BITS +: VEL_BITS] = $urandom;
            end

            it = item_of(OP_TICK, now_us, stamp, 2'($urandom_range(0, 3)), vel_type'(vbits));
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
               it.op = OP_TICK;
            end else if (pick < 56) begin
               it.op = OP_MANUAL;
            end else if (pick < 70) begin
               it.op = OP_AUTO;
            end else if (pick < 78) begin
               it.op = OP_MODE;
               if ($urandom_range(0, 9) >= 3)
                  it.setting = ($urandom_range(0, 1) == 0) ? MODE_MANUAL : MODE_AUTO;
            end else if (pick < 85) begin
               it.op = OP_AUTO_EN;
            end else if (pick < 92) begin
               it.op = OP_DEADMAN;
            end else if (pick < 97) begin
               // keep estop mostly released so the other sources get exercised
               it.op = OP_ESTOP;
               it.setting = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
            end else begin
               it.op = OP_UNUSED;
            end
            if (it.op != OP_UNUSED)
               counted++;
            send_item(it, 1'b0, '0);
         end
      end

      calm = 1'b0;
      wait_idle();
      if (mismatches == 0)
         $display("[velocity_command_arbiter] OK");
      else
         $display("[velocity_command_arbiter] ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/vca_pkg.sv
src/velocity_command_arbiter.sv
src/vca_checker.sv
bench/velocity_command_arbiter_tb.sv
